FILE: rtl/sdtq_pkg.sv
package sdtq_pkg;

	// op codes
	localparam logic [1:0] OP_SET    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_EXPIRE = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_FIRED    = 3'd3;
	localparam logic [2:0] ST_NONE_DUE = 3'd4;

	// field widths
	localparam int TIME_W = 48;
	localparam int DL_W   = 49;
	localparam int WAIT_W = 32;
	localparam int ID_W   = 8;
	localparam int ARG_W  = 32;
	localparam int CNT_W  = 5;

	// most alarms fired per expire word, and its counter width
	localparam int MAX_FIRE = 16;
	localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

	// largest reported cancel count
	localparam logic [CNT_W-1:0] CNT_SAT = 5'd31;

	// one timer slot
	typedef struct packed {
		logic             valid;
		logic [DL_W-1:0]  deadline;
		logic [ID_W-1:0]  handler;
		logic [ARG_W-1:0] arg;
	} slot_t;

	// search key broadcast to every cell
	typedef struct packed {
		logic [DL_W-1:0]  dl;
		logic [ID_W-1:0]  hid;
		logic [ARG_W-1:0] harg;
		logic             any;
	} key_t;

	// per-cycle command to the chain
	typedef struct packed {
		logic ins;
		logic cxl;
		logic pop;
	} cell_ctl_t;

endpackage

FILE: rtl/sdtq_cell.sv
module sdtq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sdtq_pkg::cell_ctl_t ctl,
	input  sdtq_pkg::key_t    key,
	input  sdtq_pkg::slot_t   lft,
	input  sdtq_pkg::slot_t   rgt,
	input  logic              lft_gt,
	input  logic              lft_open,
	input  logic              seen_in,
	output sdtq_pkg::slot_t   cur,
	output logic              gt,
	output logic              seen_out
);
	import sdtq_pkg::*;

	logic             valid_q;
	logic [DL_W-1:0]  deadline_q;
	logic [ID_W-1:0]  handler_q;
	logic [ARG_W-1:0] arg_q;
	logic             match;
	logic             take_l;
	logic             take_n;
	logic             take_r;
	slot_t            new_slot;
	slot_t            nxt;

	assign cur = '{valid: valid_q, deadline: deadline_q, handler: handler_q, arg: arg_q};

	// local compares against the broadcast key
	assign gt       = valid_q && (deadline_q > key.dl);
	assign match    = valid_q && (handler_q == key.hid) && (key.any || (arg_q == key.harg));
	assign seen_out = seen_in | match;

	// insert: later entries move right, the new one lands at the first later or empty slot
	assign take_l = ctl.ins && lft_gt;
	assign take_n = ctl.ins && !lft_gt && lft_open && (gt || !valid_q);
	// remove: everything from the first match (or the head) moves left
	assign take_r = ctl.pop || (ctl.cxl && seen_out);

	assign new_slot = '{valid: 1'b1, deadline: key.dl, handler: key.hid, arg: key.harg};

	always_comb begin
		if (take_l) begin
			nxt = lft;
		end else if (take_n) begin
			nxt = new_slot;
		end else if (take_r) begin
			nxt = rgt;
		end else begin
			nxt = cur;
		end
	end

	// occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		deadline_q <= nxt.deadline;
		handler_q  <= nxt.handler;
		arg_q      <= nxt.arg;
	end

endmodule

FILE: rtl/sorted_deadline_timer_queue.sv
// a set or an expire that fires nothing goes through the execute and emit states, and its word
// is loaded into the output registers; a cancel stays in execute, removing one match per pass.
// an expire puts out one fired alarm per pass through execute and emit.
// a new input word is taken only in idle, after the last word of the previous one is loaded.
// reset clears every slot's valid bit and the control; slot contents are not reset.
module sorted_deadline_timer_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [47:0] now_us,
	input  logic [31:0] delay_us,
	input  logic [7:0]  handler_id,
	input  logic [31:0] handler_arg,
	input  logic        any_arg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  fired_id,
	output logic [31:0] fired_arg,
	output logic [4:0]  cancel_count,
	output logic        pending,
	output logic [31:0] next_wait_us,
	output logic        last
);
	import sdtq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic              accept;
	logic [1:0]        op_q;
	logic [TIME_W-1:0] now_q;
	logic [DL_W-1:0]   dl_q;
	logic              dzero_q;
	logic [ID_W-1:0]   hid_q;
	logic [ARG_W-1:0]  harg_q;
	logic              any_q;
	logic [2:0]        res_q, res_d;
	logic [ID_W-1:0]   fid_q, fid_d;
	logic [ARG_W-1:0]  farg_q, farg_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [FIRE_W-1:0] k_q, k_d;
	cell_ctl_t         ctl;
	key_t              key;
	slot_t             cells_w [DEPTH];
	slot_t             lft_w   [DEPTH];
	slot_t             rgt_w   [DEPTH];
	logic [DEPTH:0]    gt_c;
	logic [DEPTH-1:0]  open_c;
	logic [DEPTH:0]    seen_c;
	slot_t             head;
	logic              full;
	logic              any_match;
	logic              head_due;
	logic              head_late;
	logic [DL_W-1:0]   diff;
	logic [WAIT_W-1:0] wait_w;
	logic [31:0]       cnt_w;
	logic [CNT_W-1:0]  cnt_sat;
	logic              emit_last;
	logic              out_load;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	assign key = '{dl: dl_q, hid: hid_q, harg: harg_q, any: any_q};

	// cell chain
	assign gt_c[0]   = 1'b0;
	assign open_c[0] = 1'b1;
	assign seen_c[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lft_w[i] = '0;
		end else begin : g_mid
			assign lft_w[i]  = cells_w[i-1];
			assign open_c[i] = cells_w[i-1].valid;
		end
		if (i == DEPTH - 1) begin : g_last
			assign rgt_w[i] = '0;
		end else begin : g_inner
			assign rgt_w[i] = cells_w[i+1];
		end

		sdtq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (key),
			.lft      (lft_w[i]),
			.rgt      (rgt_w[i]),
			.lft_gt   (gt_c[i]),
			.lft_open (open_c[i]),
			.seen_in  (seen_c[i]),
			.cur      (cells_w[i]),
			.gt       (gt_c[i+1]),
			.seen_out (seen_c[i+1])
		);
	end

	assign head      = cells_w[0];
	assign full      = cells_w[DEPTH-1].valid;
	assign any_match = seen_c[DEPTH];

	// head status against the item's time
	assign head_late = head.deadline > {1'b0, now_q};
	assign head_due  = head.valid && !head_late;
	assign diff      = head.deadline - {1'b0, now_q};

	always_comb begin
		if (!head.valid || !head_late) begin
			wait_w = '0;
		end else if (|diff[DL_W-1:WAIT_W]) begin
			wait_w = '1;
		end else begin
			wait_w = diff[WAIT_W-1:0];
		end
	end

	// saturated cancel count
	assign cnt_w   = 32'(cnt_q);
	assign cnt_sat = (cnt_w > 32'(CNT_SAT)) ? CNT_SAT : cnt_w[CNT_W-1:0];

	assign emit_last = (res_q != ST_FIRED) || (k_q == FIRE_W'(MAX_FIRE)) || !head_due;
	assign out_load  = (state_q == S_EMIT) && (!out_valid || !out_stall);

	// sequencer
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		res_d   = res_q;
		fid_d   = fid_q;
		farg_d  = farg_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
					cnt_d   = '0;
					k_d     = '0;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_SET: begin
						state_d = S_EMIT;
						if (dzero_q || (hid_q == '0)) begin
							res_d = ST_INVALID;
						end else if (full) begin
							res_d = ST_FULL;
						end else begin
							ctl.ins = 1'b1;
							res_d   = ST_OK;
						end
					end
					OP_CANCEL: begin
						if (hid_q == '0) begin
							res_d   = ST_INVALID;
							state_d = S_EMIT;
						end else if (any_match) begin
							ctl.cxl = 1'b1;
							cnt_d   = cnt_q + CW'(1);
						end else begin
							res_d   = ST_OK;
							state_d = S_EMIT;
						end
					end
					OP_EXPIRE: begin
						state_d = S_EMIT;
						if (head_due) begin
							ctl.pop = 1'b1;
							res_d   = ST_FIRED;
							fid_d   = head.handler;
							farg_d  = head.arg;
							k_d     = k_q + FIRE_W'(1);
						end else begin
							res_d = ST_NONE_DUE;
						end
					end
					default: begin
						res_d   = ST_INVALID;
						state_d = S_EMIT;
					end
				endcase
			end
			S_EMIT: begin
				if (out_load) begin
					state_d = emit_last ? S_IDLE : S_EXEC;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		res_q  <= res_d;
		fid_q  <= fid_d;
		farg_q <= farg_d;
		if (accept) begin
			op_q    <= op;
			now_q   <= now_us;
			dl_q    <= {1'b0, now_us} + DL_W'(delay_us);
			dzero_q <= (delay_us == '0);
			hid_q   <= handler_id;
			harg_q  <= handler_arg;
			any_q   <= any_arg;
		end
		if (out_load) begin
			status       <= res_q;
			fired_id     <= (res_q == ST_FIRED) ? fid_q : '0;
			fired_arg    <= (res_q == ST_FIRED) ? farg_q : '0;
			cancel_count <= cnt_sat;
			pending      <= head.valid;
			next_wait_us <= wait_w;
			last         <= emit_last;
		end
	end

endmodule

FILE: rtl/sdtq_checker.sv
module sdtq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [7:0]  fired_id,
	input logic        pending,
	input logic [31:0] next_wait_us,
	input logic        last
);
	import sdtq_pkg::*;

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
		else $error("result word changed while stalled");

	// one input word in flight at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

	// a fired alarm always carries a real handler
	a_fired_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FIRED) |-> (fired_id != '0))
		else $error("fired alarm with null handler");

	// only fired words can be followed by more words of the same input
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_FIRED) |-> last)
		else $error("non-fired result word not marked last");

	// an empty queue reports no wait
	a_empty_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pending |-> (next_wait_us == '0))
		else $error("wait reported with no pending alarm");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (.*);

FILE: dv/tb_sorted_deadline_timer_queue.sv
`timescale 1ns / 100ps

module tb_sorted_deadline_timer_queue;

	import sdtq_pkg::*;

	localparam int TQ_DEPTH = 16;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int RANDOM_WORDS = 310;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int RUN_LIMIT = 2000000;
	localparam int REPORT_MAX = 10;

	// one request word and one response word
	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] now_us;
		logic [31:0] delay_us;
		logic [7:0]  handler_id;
		logic [31:0] handler_arg;
		logic        any_arg;
	} alarm_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  fired_id;
		logic [31:0] fired_arg;
		logic [4:0]  cancel_count;
		logic        pending;
		logic [31:0] next_wait_us;
		logic        last;
	} alarm_rsp_t;

	// directed row: request, repeat count (argument steps per copy), optional typed response
	typedef struct {
		alarm_req_t req;
		int         rep;
		bit         typed;
		alarm_rsp_t rsp;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [47:0] now_us;
	logic [31:0] delay_us;
	logic [7:0]  handler_id;
	logic [31:0] handler_arg;
	logic        any_arg;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  fired_id;
	logic [31:0] fired_arg;
	logic [4:0]  cancel_count;
	logic        pending;
	logic [31:0] next_wait_us;
	logic        last;

	// shadow alarm table, kept sorted by deadline
	logic [48:0] tbl_deadline [TQ_DEPTH];
	logic [7:0]  tbl_handler [TQ_DEPTH];
	logic [31:0] tbl_arg [TQ_DEPTH];
	int          tbl_count = 0;

	alarm_rsp_t  awaited_rsp [$];
	dir_row_t    dir_rows [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          send_burst = 0;
	bit          hold_off_req = 1'b0;
	logic [47:0] sim_now_us = 48'h0000_0010_0000;

	sorted_deadline_timer_queue #(
		.DEPTH(TQ_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.now_us(now_us),
		.delay_us(delay_us),
		.handler_id(handler_id),
		.handler_arg(handler_arg),
		.any_arg(any_arg),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.fired_id(fired_id),
		.fired_arg(fired_arg),
		.cancel_count(cancel_count),
		.pending(pending),
		.next_wait_us(next_wait_us),
		.last(last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response built from the table as it stands after the update
	function automatic void push_rsp(input logic [2:0] st, input logic [7:0] fid,
			input logic [31:0] farg, input int cnt, input logic fin, input logic [47:0] now);
		alarm_rsp_t r;
		logic [48:0] diff;
		r = '0;
		r.status = st;
		r.fired_id = fid;
		r.fired_arg = farg;
		r.cancel_count = (cnt > 31) ? CNT_SAT : cnt[4:0];
		r.pending = (tbl_count > 0);
		if (tbl_count > 0 && tbl_deadline[0] > {1'b0, now}) begin
			diff = tbl_deadline[0] - {1'b0, now};
			r.next_wait_us = (diff > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
		end
		r.last = fin;
		awaited_rsp.push_back(r);
	endfunction

	// close the gap left by a removed slot
	function automatic void drop_slot(input int idx);
		int i;
		for (i = idx; i + 1 < tbl_count; i++) begin
			tbl_deadline[i] = tbl_deadline[i + 1];
			tbl_handler[i] = tbl_handler[i + 1];
			tbl_arg[i] = tbl_arg[i + 1];
		end
		tbl_count--;
	endfunction

	// apply one request to the shadow table and queue the responses it causes
	function automatic void advance_alarm_table(input alarm_req_t rq);
		logic [48:0] dl;
		logic [7:0]  fid;
		logic [31:0] farg;
		logic        fin;
		int          pos;
		int          i;
		int          removed;
		int          fired;
		case (rq.op)
			OP_SET: begin
				if (rq.delay_us == '0 || rq.handler_id == '0) begin
					push_rsp(ST_INVALID, '0, '0, 0, 1'b1, rq.now_us);
				end else if (tbl_count >= TQ_DEPTH) begin
					push_rsp(ST_FULL, '0, '0, 0, 1'b1, rq.now_us);
				end else begin
					// ties go behind older entries
					dl = {1'b0, rq.now_us} + {17'd0, rq.delay_us};
					pos = 0;
					while (pos < tbl_count && tbl_deadline[pos] <= dl)
						pos++;
					for (i = tbl_count; i > pos; i--) begin
						tbl_deadline[i] = tbl_deadline[i - 1];
						tbl_handler[i] = tbl_handler[i - 1];
						tbl_arg[i] = tbl_arg[i - 1];
					end
					tbl_deadline[pos] = dl;
					tbl_handler[pos] = rq.handler_id;
					tbl_arg[pos] = rq.handler_arg;
					tbl_count++;
					push_rsp(ST_OK, '0, '0, 0, 1'b1, rq.now_us);
				end
			end
			OP_CANCEL: begin
				if (rq.handler_id == '0) begin
					push_rsp(ST_INVALID, '0, '0, 0, 1'b1, rq.now_us);
				end else begin
					i = 0;
					removed = 0;
					while (i < tbl_count) begin
						if (tbl_handler[i] == rq.handler_id &&
								(rq.any_arg || tbl_arg[i] == rq.handler_arg)) begin
							drop_slot(i);
							removed++;
						end else begin
							i++;
						end
					end
					push_rsp(ST_OK, '0, '0, removed, 1'b1, rq.now_us);
				end
			end
			OP_EXPIRE: begin
				fired = 0;
				while (fired < MAX_FIRE && tbl_count > 0 &&
						tbl_deadline[0] <= {1'b0, rq.now_us}) begin
					fid = tbl_handler[0];
					farg = tbl_arg[0];
					drop_slot(0);
					fin = (fired + 1 == MAX_FIRE) || tbl_count == 0 ||
						tbl_deadline[0] > {1'b0, rq.now_us};
					push_rsp(ST_FIRED, fid, farg, 0, fin, rq.now_us);
					fired++;
				end
				if (fired == 0)
					push_rsp(ST_NONE_DUE, '0, '0, 0, 1'b1, rq.now_us);
			end
			default: begin
				push_rsp(ST_INVALID, '0, '0, 0, 1'b1, rq.now_us);
			end
		endcase
	endfunction

	function automatic dir_row_t mk_row(input logic [1:0] o, input logic [47:0] now,
			input logic [31:0] dly, input logic [7:0] hid, input logic [31:0] harg,
			input logic any, input int rep);
		dir_row_t r;
		r.req = {o, now, dly, hid, harg, any};
		r.rep = rep;
		r.typed = 1'b0;
		r.rsp = '0;
		return r;
	endfunction

	// attach a response that can be read off directly
	function automatic dir_row_t with_rsp(input dir_row_t r, input logic [2:0] st,
			input logic [4:0] cnt, input logic pend, input logic [31:0] wt);
		r.typed = 1'b1;
		r.rsp = {st, 8'd0, 32'd0, cnt, pend, wt, 1'b1};
		return r;
	endfunction

	// gaps between words: mostly short, a few long, with runs of back-to-back words
	function automatic int pick_send_gap();
		int pick;
		pick = $urandom_range(99);
		if (send_burst > 0) begin
			send_burst--;
			return 0;
		end
		if (pick < 5) begin
			send_burst = $urandom_range(40, 20);
			return 0;
		end
		if (pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(3, 1);
		if (pick < 96)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// random request around a moving time base
	function automatic alarm_req_t rand_req();
		alarm_req_t  w;
		logic [63:0] wide;
		int          pick;
		pick = $urandom_range(99);
		// time moves forward, now and then by a large jump
		if ($urandom_range(99) < 3)
			sim_now_us = sim_now_us + {16'd0, $urandom()};
		else
			sim_now_us = sim_now_us + 48'($urandom_range(300));
		if (pick < 45)
			w.op = OP_SET;
		else if (pick < 64)
			w.op = OP_CANCEL;
		else if (pick < 96)
			w.op = OP_EXPIRE;
		else
			w.op = OP_UNKNOWN;
		pick = $urandom_range(99);
		wide = {$urandom(), $urandom()};
		if (pick < 88)
			w.now_us = sim_now_us;
		else if (pick < 95)
			w.now_us = wide[47:0];
		else
			w.now_us = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(5000));
		pick = $urandom_range(99);
		if (pick < 70)
			w.delay_us = $urandom_range(1500, 1);
		else if (pick < 80)
			w.delay_us = $urandom_range(5, 1);
		else if (pick < 95)
			w.delay_us = $urandom();
		else
			w.delay_us = '0;
		pick = $urandom_range(99);
		if (pick < 85)
			w.handler_id = 8'($urandom_range(6, 1));
		else if (pick < 96)
			w.handler_id = 8'($urandom_range(255));
		else
			w.handler_id = '0;
		w.handler_arg = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom();
		w.any_arg = 1'($urandom_range(1));
		return w;
	endfunction

	// drive one word at the falling edge and hold it until it is taken
	task automatic send_word(input alarm_req_t rq, input int gap, input bit typed,
			input alarm_rsp_t typed_rsp);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= rq.op;
		now_us <= rq.now_us;
		delay_us <= rq.delay_us;
		handler_id <= rq.handler_id;
		handler_arg <= rq.handler_arg;
		any_arg <= rq.any_arg;
		do @(posedge clk); while (in_stall);
		advance_alarm_table(rq);
		if (typed)
			awaited_rsp[$] = typed_rsp;
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string what, input alarm_rsp_t want,
			input alarm_rsp_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t %s: want st=%0d id=%0d arg=%0h cnt=%0d pend=%0b wait=%0d last=%0b",
				$realtime, what, want.status, want.fired_id, want.fired_arg,
				want.cancel_count, want.pending, want.next_wait_us, want.last);
			$display("%0t %s:  got st=%0d id=%0d arg=%0h cnt=%0d pend=%0b wait=%0d last=%0b",
				$realtime, what, got.status, got.fired_id, got.fired_arg,
				got.cancel_count, got.pending, got.next_wait_us, got.last);
		end
	endtask

	// response checker
	always @(posedge clk) begin : rsp_check
		alarm_rsp_t got_rsp;
		alarm_rsp_t want_rsp;
		if (arst_n && out_valid && !out_stall) begin
			got_rsp = {status, fired_id, fired_arg, cancel_count, pending, next_wait_us, last};
			if (awaited_rsp.size() == 0) begin
				note_mismatch("word with nothing expected", '0, got_rsp);
			end else begin
				want_rsp = awaited_rsp.pop_front();
				if (got_rsp !== want_rsp)
					note_mismatch("word mismatch", want_rsp, got_rsp);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stall pattern, plus one long hold-off on request
	initial begin : receiver
		int pick;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			pick = $urandom_range(99);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (pick < 10) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(60, 20)) @(negedge clk);
			end else if (pick < 60) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(4, 1)) @(negedge clk);
			end else if (pick < 95) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(3, 1)) @(negedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(40, 10)) @(negedge clk);
			end
		end
	end

	// sender: reset, directed table, random words, drain
	initial begin : sender
		alarm_req_t rq;
		int         n;
		int         k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_SET;
		now_us = '0;
		delay_us = '0;
		handler_id = '0;
		handler_arg = '0;
		any_arg = 1'b0;

		// empty table, then the invalid forms
		dir_rows.push_back(with_rsp(mk_row(OP_EXPIRE, 48'd0, 32'd0, 8'd0, 32'd0, 1'b0, 1),
			ST_NONE_DUE, 5'd0, 1'b0, 32'd0));
		dir_rows.push_back(with_rsp(mk_row(OP_SET, 48'd50, 32'd0, 8'd5, 32'd1, 1'b0, 1),
			ST_INVALID, 5'd0, 1'b0, 32'd0));
		dir_rows.push_back(with_rsp(mk_row(OP_SET, 48'd50, 32'd10, 8'd0, 32'd1, 1'b1, 1),
			ST_INVALID, 5'd0, 1'b0, 32'd0));
		dir_rows.push_back(with_rsp(mk_row(OP_CANCEL, 48'd50, 32'd10, 8'd0, 32'd1, 1'b1, 1),
			ST_INVALID, 5'd0, 1'b0, 32'd0));
		dir_rows.push_back(with_rsp(mk_row(OP_UNKNOWN, 48'd50, 32'd10, 8'd9, 32'd1, 1'b0, 1),
			ST_INVALID, 5'd0, 1'b0, 32'd0));
		// field extremes
		dir_rows.push_back(with_rsp(mk_row(OP_SET, 48'd0, 32'hFFFF_FFFF, 8'hFF,
			32'hFFFF_FFFF, 1'b0, 1), ST_OK, 5'd0, 1'b1, 32'hFFFF_FFFF));
		dir_rows.push_back(mk_row(OP_SET, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 32'd0,
			1'b1, 1));
		// cancel with no match, then with a wildcard argument
		dir_rows.push_back(with_rsp(mk_row(OP_CANCEL, 48'd0, 32'd0, 8'd1, 32'd5, 1'b0, 1),
			ST_OK, 5'd0, 1'b1, 32'hFFFF_FFFF));
		dir_rows.push_back(with_rsp(mk_row(OP_CANCEL, 48'd0, 32'd0, 8'd1, 32'd5, 1'b1, 1),
			ST_OK, 5'd1, 1'b1, 32'hFFFF_FFFF));
		// fill with equal deadlines, then overflow
		dir_rows.push_back(mk_row(OP_SET, 48'd100, 32'd1000, 8'd7, 32'd0, 1'b0, 15));
		dir_rows.push_back(with_rsp(mk_row(OP_SET, 48'd100, 32'd20, 8'd2, 32'd0, 1'b0, 1),
			ST_FULL, 5'd0, 1'b1, 32'd1000));
		// exact-argument cancel out of a tie group
		dir_rows.push_back(mk_row(OP_CANCEL, 48'd100, 32'd0, 8'd7, 32'd3, 1'b0, 1));
		// one microsecond early, then fire everything in order
		dir_rows.push_back(with_rsp(mk_row(OP_EXPIRE, 48'd1099, 32'd0, 8'd0, 32'd0, 1'b0, 1),
			ST_NONE_DUE, 5'd0, 1'b1, 32'd1));
		dir_rows.push_back(mk_row(OP_EXPIRE, 48'hFFFF_FFFF_FFFF, 32'd0, 8'd0, 32'd0, 1'b0, 1));
		dir_rows.push_back(with_rsp(mk_row(OP_EXPIRE, 48'hFFFF_FFFF_FFFF, 32'd0, 8'd0,
			32'd0, 1'b0, 1), ST_NONE_DUE, 5'd0, 1'b0, 32'd0));

		// reset
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words
		for (n = 0; n < dir_rows.size(); n++) begin
			for (k = 0; k < dir_rows[n].rep; k++) begin
				rq = dir_rows[n].req;
				rq.handler_arg = rq.handler_arg + k;
				send_word(rq, pick_send_gap(), dir_rows[n].typed, dir_rows[n].rsp);
			end
		end

		// random words, with one long receiver hold-off along the way
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 60)
				hold_off_req = 1'b1;
			if (n >= 60 && n < 120)
				send_word(rand_req(), 0, 1'b0, '0);
			else
				send_word(rand_req(), pick_send_gap(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		// drain
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
